>>> hw/rtl/rawdt_pkg.sv
// ----------------------------------------------------------------------------
// rawdt_pkg
// Shared types, constants and size helpers for the dirty-tracking RAM block.
// ----------------------------------------------------------------------------
package rawdt_pkg;

  localparam int DATA_W = 64;
  localparam int CFG_W  = 32;
  localparam int SIZE_W = 7;
  localparam int PAGE_W = 9;

  // supported access sizes in bytes
  localparam logic [SIZE_W-1:0] SZ_1  = 7'd1;
  localparam logic [SIZE_W-1:0] SZ_2  = 7'd2;
  localparam logic [SIZE_W-1:0] SZ_4  = 7'd4;
  localparam logic [SIZE_W-1:0] SZ_8  = 7'd8;
  localparam logic [SIZE_W-1:0] SZ_16 = 7'd16;
  localparam logic [SIZE_W-1:0] SZ_32 = 7'd32;
  localparam logic [SIZE_W-1:0] SZ_64 = 7'd64;

  // configuration register indexes
  localparam logic [1:0] REG_RAM_BASE = 2'd0;
  localparam logic [1:0] REG_FB_BASE  = 2'd1;
  localparam logic [1:0] REG_FB_SIZE  = 2'd2;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } ram_ctl_t;

  function automatic logic size_ok(input logic [SIZE_W-1:0] n);
    return (n == SZ_1) || (n == SZ_2) || (n == SZ_4) || (n == SZ_8) ||
           (n == SZ_16) || (n == SZ_32) || (n == SZ_64);
  endfunction

  // beat index mask of a burst; zero for single-word sizes
  function automatic logic [2:0] beat_mask(input logic [SIZE_W-1:0] n);
    logic [2:0] m;
    case (n)
      SZ_16:   m = 3'd1;
      SZ_32:   m = 3'd3;
      SZ_64:   m = 3'd7;
      default: m = 3'd0;
    endcase
    return m;
  endfunction

  // data mask of an access; full word for 8 bytes and up
  function automatic logic [DATA_W-1:0] byte_mask(input logic [SIZE_W-1:0] n);
    logic [DATA_W-1:0] m;
    case (n)
      SZ_1:    m = 64'h0000_0000_0000_00ff;
      SZ_2:    m = 64'h0000_0000_0000_ffff;
      SZ_4:    m = 64'h0000_0000_ffff_ffff;
      default: m = '1;
    endcase
    return m;
  endfunction

endpackage

>>> hw/rtl/rawdt_cdiv.sv
// ----------------------------------------------------------------------------
// rawdt_cdiv
// Three-stage divider by a constant: reciprocal multiply, back-multiply,
// one correction step. Quotient and remainder are exact for any W-bit input.
// ----------------------------------------------------------------------------
module rawdt_cdiv #(
  parameter int W   = 32,
  parameter int DIV = 1024,
  parameter int RW  = $clog2(DIV)
) (
  input  logic          clk,
  input  logic [W-1:0]  x_i,
  output logic [W-1:0]  q_o,
  output logic [RW-1:0] r_o
);

  // floor(2^W / DIV): estimate is low by at most one
  localparam logic [W-1:0] RECIP = W'((64'd1 << W) / DIV);
  localparam logic [W-1:0] DIV_W = W'(DIV);

  logic [2*W-1:0] prod1_nxt;
  logic [2*W-1:0] prod2_nxt;
  logic [W:0]     rem_nxt;
  logic           fix_nxt;

  logic [W-1:0]   x1_r, x2_r, q1_r, q2_r, q_r;
  logic [W:0]     p2_r;
  logic [RW-1:0]  r_r;

  assign prod1_nxt = {{W{1'b0}}, x_i} * {{W{1'b0}}, RECIP};
  assign prod2_nxt = {{W{1'b0}}, q1_r} * {{W{1'b0}}, DIV_W};
  assign rem_nxt   = {1'b0, x2_r} - p2_r;
  assign fix_nxt   = rem_nxt >= {1'b0, DIV_W};

  always_ff @(posedge clk) begin
    x1_r <= x_i;
    q1_r <= prod1_nxt[2*W-1:W];
    x2_r <= x1_r;
    q2_r <= q1_r;
    p2_r <= prod2_nxt[W:0];
    q_r  <= q2_r + W'(fix_nxt);
    r_r  <= fix_nxt ? RW'(rem_nxt - {1'b0, DIV_W}) : RW'(rem_nxt);
  end

  assign q_o = q_r;
  assign r_o = r_r;

endmodule

>>> hw/rtl/rawdt_ram.sv
// ----------------------------------------------------------------------------
// rawdt_ram
// Single-port 64-bit word memory, registered read, zero-fill sweep after reset.
// ----------------------------------------------------------------------------
module rawdt_ram import rawdt_pkg::*; #(
  parameter int DEPTH = 65536,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ram_ctl_t          ctl,
  input  logic [AW-1:0]     addr,
  input  logic [DATA_W-1:0] wr_data,
  output logic [DATA_W-1:0] rd_data,
  output logic              clr_busy
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;
  logic              clr_active_r;
  logic [AW-1:0]     clr_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_idx_r    <= '0;
    end else if (clr_active_r) begin
      if (clr_idx_r == AW'(DEPTH - 1)) begin
        clr_active_r <= 1'b0;
      end
      clr_idx_r <= clr_idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_active_r) begin
      mem[clr_idx_r] <= '0;
    end else if (ctl.wr_en) begin
      mem[addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data_r <= mem[addr];
    end
  end

  assign rd_data  = rd_data_r;
  assign clr_busy = clr_active_r;

endmodule

>>> hw/rtl/ram_access_with_dirty_tracking_core.sv
// ----------------------------------------------------------------------------
// ram_access_with_dirty_tracking_core
// Little-endian word RAM with dirty-page and framebuffer-window reporting.
//
//   channel   handshake                     payload
//   input     start / busy                  in_operation .. in_write_data
//   result    out_valid (one-cycle strobe)  out_read_data .. out_dirty_end_page
//   config    APB psel/penable/pwrite       paddr, pwdata, prdata
//
// Each word passes through the constant dividers (word index and page
// numbers), one memory read and one merge/write-back; the result strobe
// comes while busy is already low. A new word is taken only when busy is low.
// After reset the memory is zero-filled, a sweep over all RAM_WORDS words
// with busy high; config writes are taken during that sweep.
// The receiver cannot stall; each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module ram_access_with_dirty_tracking_core import rawdt_pkg::*; #(
  parameter int RAM_WORDS  = 65536,
  parameter int PAGE_BYTES = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic              in_operation,
  input  logic [31:0]       in_address,
  input  logic [SIZE_W-1:0] in_access_bytes,
  input  logic [2:0]        in_beat,
  input  logic [DATA_W-1:0] in_write_data,
  output logic              out_valid,
  output logic [DATA_W-1:0] out_read_data,
  output logic              out_ok,
  output logic              out_fb_touched,
  output logic              out_dirty_valid,
  output logic [PAGE_W-1:0] out_dirty_page,
  output logic              out_dirty_end_valid,
  output logic [PAGE_W-1:0] out_dirty_end_page,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [CFG_W-1:0]  pwdata,
  output logic [CFG_W-1:0]  prdata,
  output logic              pready
);

  localparam int WAW     = $clog2(RAM_WORDS);
  localparam int XW      = 30;
  localparam int DIV_LAT = 3;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_RD   = 2'd2;
  localparam logic [1:0] ST_WB   = 2'd3;

  // config
  logic [CFG_W-1:0] ram_base_r, fb_base_r, fb_size_r;
  logic             cfg_wr;

  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ram_base_r <= '0;
      fb_base_r  <= '0;
      fb_size_r  <= '0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_RAM_BASE: ram_base_r <= pwdata;
        REG_FB_BASE:  fb_base_r  <= pwdata;
        REG_FB_SIZE:  fb_size_r  <= pwdata;
        default:      ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_RAM_BASE: prdata = ram_base_r;
      REG_FB_BASE:  prdata = fb_base_r;
      REG_FB_SIZE:  prdata = fb_size_r;
      default:      prdata = '0;
    endcase
  end

  // control
  logic [1:0] state_r, state_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       clr_busy;
  logic       accept;

  assign busy   = (state_r != ST_IDLE) || clr_busy;
  assign accept = start && !busy;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_DIV;
          cnt_nxt   = '0;
        end
      end
      ST_DIV: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 2'(DIV_LAT - 1)) begin
          state_nxt = ST_RD;
        end
      end
      ST_RD:   state_nxt = ST_WB;
      ST_WB:   state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // accept-time decode
  logic [31:0]       off_nxt, offend_nxt;
  logic [2:0]        beat_nxt;
  logic [XW-1:0]     x_nxt;

  assign off_nxt    = in_address - ram_base_r;
  assign offend_nxt = in_address - ram_base_r + 32'(in_access_bytes) - 32'd1;
  assign beat_nxt   = in_beat & beat_mask(in_access_bytes);
  assign x_nxt      = {1'b0, off_nxt[31:3]} + XW'(beat_nxt);

  logic              op_r, good_r, burst_r, beat0_r;
  logic [SIZE_W-1:0] n_r;
  logic [DATA_W-1:0] wdata_r;
  logic [31:0]       off_r, offend_r;
  logic [XW-1:0]     x_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= in_operation;
      n_r      <= in_access_bytes;
      good_r   <= size_ok(in_access_bytes);
      burst_r  <= beat_mask(in_access_bytes) != 3'd0;
      beat0_r  <= beat_nxt == 3'd0;
      wdata_r  <= in_write_data;
      off_r    <= off_nxt;
      offend_r <= offend_nxt;
      x_r      <= x_nxt;
    end
  end

  // word index and page numbers
  logic [WAW-1:0] widx;
  logic [31:0]    page_q, page_end_q;

  rawdt_cdiv #(.W(XW), .DIV(RAM_WORDS), .RW(WAW)) u_widx_div (
    .clk (clk),
    .x_i (x_r),
    .q_o (),
    .r_o (widx)
  );

  rawdt_cdiv #(.W(32), .DIV(PAGE_BYTES)) u_page_div (
    .clk (clk),
    .x_i (off_r),
    .q_o (page_q),
    .r_o ()
  );

  rawdt_cdiv #(.W(32), .DIV(PAGE_BYTES)) u_page_end_div (
    .clk (clk),
    .x_i (offend_r),
    .q_o (page_end_q),
    .r_o ()
  );

  // memory
  ram_ctl_t          ram_ctl;
  logic [DATA_W-1:0] rdata, merged;

  assign ram_ctl.rd_en = state_r == ST_RD;
  assign ram_ctl.wr_en = (state_r == ST_WB) && op_r && good_r;

  rawdt_ram #(.DEPTH(RAM_WORDS), .AW(WAW)) u_ram (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ram_ctl),
    .addr     (widx),
    .wr_data  (merged),
    .rd_data  (rdata),
    .clr_busy (clr_busy)
  );

  // lane merge and flags
  logic [SIZE_W-1:0] nm1;
  logic [2:0]        lane;
  logic [5:0]        sh;
  logic [DATA_W-1:0] mask;
  logic [DATA_W-1:0] rd_lane;
  logic [31:0]       fb_start;
  logic              overlap;
  logic              dv, dev, fb;

  assign nm1     = n_r - 7'd1;
  // small accesses are forced onto a naturally aligned lane
  assign lane    = off_r[2:0] & ~nm1[2:0];
  assign sh      = {lane, 3'b000};
  assign mask    = byte_mask(n_r);
  assign rd_lane = (rdata >> sh) & mask;
  assign merged  = (rdata & ~(mask << sh)) | ((wdata_r & mask) << sh);

  // wrap-safe window test
  assign fb_start = fb_base_r - ram_base_r;
  assign overlap  = (fb_size_r == '0) || ((off_r - fb_start) < fb_size_r) ||
                    ((fb_start - off_r) < 32'(n_r));

  // start page is marked even for a bad size
  assign dv  = op_r && beat0_r;
  assign fb  = dv && good_r && overlap;
  assign dev = dv && burst_r && ((off_r[5:0] & nm1[5:0]) != 6'd0);

  logic              out_valid_r;
  logic [DATA_W-1:0] out_read_data_r;
  logic              out_ok_r, out_fb_r, out_dv_r, out_dev_r;
  logic [PAGE_W-1:0] out_dp_r, out_dep_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= state_r == ST_WB;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_WB) begin
      out_read_data_r <= (!op_r && good_r) ? rd_lane : '0;
      out_ok_r        <= good_r;
      out_fb_r        <= fb;
      out_dv_r        <= dv;
      out_dp_r        <= dv ? page_q[PAGE_W-1:0] : '0;
      out_dev_r       <= dev;
      out_dep_r       <= dev ? page_end_q[PAGE_W-1:0] : '0;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_read_data       = out_read_data_r;
  assign out_ok              = out_ok_r;
  assign out_fb_touched      = out_fb_r;
  assign out_dirty_valid     = out_dv_r;
  assign out_dirty_page      = out_dp_r;
  assign out_dirty_end_valid = out_dev_r;
  assign out_dirty_end_page  = out_dep_r;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("busy not raised after accepting a word");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
    ram_ctl.wr_en |-> (state_r == ST_WB) && !clr_busy)
    else $error("memory write outside write-back");

  a_bad_size: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ok) |-> (out_read_data == '0) && !out_fb_touched &&
                               !out_dirty_end_valid)
    else $error("unsupported size produced data or flags");

endmodule

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench for the dirty-tracking RAM core. A shadow memory predicts every
// read word, the dirty-page and end-page reports and the framebuffer window
// flag. Each strobed result is checked in order against the oldest
// prediction. Directed accesses come first, then a framebuffer window check,
// then random traffic over several register settings.
// ----------------------------------------------------------------------------
module tb;
  import rawdt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RAM_WORDS_TB  = 65536;
  localparam int PAGE_BYTES_TB = 1024;
  localparam int RAM_BYTES     = RAM_WORDS_TB * 8;
  localparam int LIMIT_CYCLES  = 600000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 235;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              ok;
    logic              fb_touched;
    logic              dirty_valid;
    logic [PAGE_W-1:0] dirty_page;
    logic              dirty_end_valid;
    logic [PAGE_W-1:0] dirty_end_page;
  } result_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic              in_operation;
  logic [31:0]       in_address;
  logic [SIZE_W-1:0] in_access_bytes;
  logic [2:0]        in_beat;
  logic [DATA_W-1:0] in_write_data;
  logic              out_valid;
  logic [DATA_W-1:0] out_read_data;
  logic              out_ok;
  logic              out_fb_touched;
  logic              out_dirty_valid;
  logic [PAGE_W-1:0] out_dirty_page;
  logic              out_dirty_end_valid;
  logic [PAGE_W-1:0] out_dirty_end_page;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [3:0]        paddr;
  logic [CFG_W-1:0]  pwdata;
  logic [CFG_W-1:0]  prdata;
  logic              pready;

  // predictor state
  logic [DATA_W-1:0] ram_shadow [RAM_WORDS_TB];
  logic [31:0]       ram_base_cfg;
  logic [31:0]       fb_base_cfg;
  logic [31:0]       fb_size_cfg;
  result_t           pending_results [$];
  result_t           want;

  int errors;
  int cycle_count;
  int words_sent;
  int reads_ok;
  int writes_ok;
  int bad_sizes;
  int fb_hits;
  int end_page_hits;
  int cfg_writes;
  bit gaps_on;
  int run_left;

  ram_access_with_dirty_tracking_core #(
    .RAM_WORDS (RAM_WORDS_TB),
    .PAGE_BYTES(PAGE_BYTES_TB)
  ) DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_operation       (in_operation),
    .in_address         (in_address),
    .in_access_bytes    (in_access_bytes),
    .in_beat            (in_beat),
    .in_write_data      (in_write_data),
    .out_valid          (out_valid),
    .out_read_data      (out_read_data),
    .out_ok             (out_ok),
    .out_fb_touched     (out_fb_touched),
    .out_dirty_valid    (out_dirty_valid),
    .out_dirty_page     (out_dirty_page),
    .out_dirty_end_valid(out_dirty_end_valid),
    .out_dirty_end_page (out_dirty_end_page),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("%0t timeout, %0d results still outstanding", $time, pending_results.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic size_supported(input logic [SIZE_W-1:0] n);
    case (n)
      SZ_1, SZ_2, SZ_4, SZ_8, SZ_16, SZ_32, SZ_64: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic [PAGE_W-1:0] page_index(input logic [31:0] off);
    return PAGE_W'(off / PAGE_BYTES_TB);
  endfunction

  // wrap-safe overlap of [off, off+n) with the window, both relative to ram_base
  function automatic logic fb_overlap(input logic [31:0] off, input logic [SIZE_W-1:0] n);
    logic [31:0] win_start;
    logic [31:0] into_win;
    logic [31:0] before_win;
    win_start  = fb_base_cfg - ram_base_cfg;
    into_win   = off - win_start;
    before_win = win_start - off;
    return (fb_size_cfg == 32'd0) || (into_win < fb_size_cfg) || (before_win < 32'(n));
  endfunction

  function automatic result_t predict_access(input logic wr, input logic [31:0] addr,
                                             input logic [SIZE_W-1:0] n,
                                             input logic [2:0] beat_in,
                                             input logic [DATA_W-1:0] wdata);
    result_t           r;
    logic [31:0]       off;
    logic [31:0]       last;
    logic              good;
    logic              burst;
    logic [2:0]        bt;
    logic [2:0]        lane;
    int unsigned       widx;
    int unsigned       sh;
    logic [DATA_W-1:0] m;
    r     = '0;
    off   = addr - ram_base_cfg;
    good  = size_supported(n);
    burst = good && (n > SZ_8);
    bt    = burst ? (beat_in & 3'((n >> 3) - 1)) : 3'd0;
    widx  = ((off >> 3) + bt) % RAM_WORDS_TB;
    r.ok  = good;

    // dirty page is reported even for a bad size
    if (wr && bt == 3'd0) begin
      r.dirty_valid = 1'b1;
      r.dirty_page  = page_index(off);
      if (good) begin
        r.fb_touched = fb_overlap(off, n);
        if (burst && (off & (32'(n) - 32'd1)) != 32'd0) begin
          last              = off + 32'(n) - 32'd1;
          r.dirty_end_valid = 1'b1;
          r.dirty_end_page  = page_index(last);
        end
      end
    end

    if (good) begin
      if (n >= SZ_8) begin
        if (wr) ram_shadow[widx] = wdata;
        else r.read_data = ram_shadow[widx];
      end else begin
        lane = off[2:0] & ~3'(n - 1);
        sh   = lane * 8;
        m    = (64'd1 << (8 * n)) - 64'd1;
        if (wr) ram_shadow[widx] = (ram_shadow[widx] & ~(m << sh)) | ((wdata & m) << sh);
        else r.read_data = (ram_shadow[widx] >> sh) & m;
      end
    end
    return r;
  endfunction

  // ------------------------------------------------------------------ checker

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (act_v !== exp_v) begin
      errors++;
      $display("%0t mismatch on %s: expected %h, actual %h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t unexpected result word: expected none, actual read_data %h",
                 $time, out_read_data);
      end else begin
        want = pending_results.pop_front();
        check_field("read_data", want.read_data, out_read_data);
        check_field("ok", 64'(want.ok), 64'(out_ok));
        check_field("fb_touched", 64'(want.fb_touched), 64'(out_fb_touched));
        check_field("dirty_valid", 64'(want.dirty_valid), 64'(out_dirty_valid));
        check_field("dirty_page", 64'(want.dirty_page), 64'(out_dirty_page));
        check_field("dirty_end_valid", 64'(want.dirty_end_valid),
                    64'(out_dirty_end_valid));
        check_field("dirty_end_page", 64'(want.dirty_end_page), 64'(out_dirty_end_page));
      end
    end
  end

  // ---------------------------------------------------------------- drivers

  task automatic issue_access(input logic wr, input logic [31:0] addr,
                              input logic [SIZE_W-1:0] n, input logic [2:0] beat_in,
                              input logic [DATA_W-1:0] wdata);
    result_t r;
    @(negedge clk);
    start           <= 1'b1;
    in_operation    <= wr;
    in_address      <= addr;
    in_access_bytes <= n;
    in_beat         <= beat_in;
    in_write_data   <= wdata;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    r = predict_access(wr, addr, n, beat_in, wdata);
    pending_results.push_back(r);
    words_sent++;
    if (!r.ok) bad_sizes++;
    else if (wr) writes_ok++;
    else reads_ok++;
    if (r.fb_touched) fb_hits++;
    if (r.dirty_end_valid) end_page_hits++;
    // start stays high across back-to-back words; a gap lowers it
    if (gaps_on) begin
      run_left--;
      if (run_left <= 0) begin
        @(negedge clk);
        start <= 1'b0;
        repeat ($urandom_range(0, 6)) @(negedge clk);
        run_left = $urandom_range(1, 12);
      end
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    case (idx)
      REG_RAM_BASE: ram_base_cfg = value;
      REG_FB_BASE:  fb_base_cfg  = value;
      REG_FB_SIZE:  fb_size_cfg  = value;
      default: ;
    endcase
    cfg_writes++;
    // read back
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    check_field("prdata", 64'(value), 64'(prdata));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_config(input logic [31:0] rb, input logic [31:0] fbb,
                            input logic [31:0] fbs);
    write_reg(REG_RAM_BASE, rb);
    write_reg(REG_FB_BASE, fbb);
    write_reg(REG_FB_SIZE, fbs);
  endtask

  // every word issued yields one result, so an empty queue means idle
  task automatic drain;
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // mostly a small hot region so reads hit earlier writes
  function automatic logic [31:0] pick_offset();
    case ($urandom_range(0, 9))
      0:       return $urandom();
      1:       return RAM_BYTES - $urandom_range(1, 256);
      2:       return ($urandom_range(1, 8191) * RAM_BYTES) + $urandom_range(0, 8191);
      default: return $urandom_range(0, 8191);
    endcase
  endfunction

  task automatic run_burst(input bit broken);
    logic [SIZE_W-1:0] n;
    logic [31:0]       off;
    logic              wr;
    int                beats;
    logic [2:0]        bi;
    n     = SZ_16 << $urandom_range(0, 2);
    beats = int'(n >> 3);
    wr    = 1'($urandom_range(0, 1));
    off   = pick_offset();
    case ($urandom_range(0, 5))
      0:       off = off & ~32'h7;
      1:       ;
      default: off = off & ~(32'(n) - 32'd1);
    endcase
    for (int b = 0; b < beats; b++) begin
      bi = 3'(b);
      if (broken) begin
        if ($urandom_range(0, 3) == 0) break;
        bi = 3'($urandom_range(0, 7));
      end
      issue_access(wr, ram_base_cfg + off, n, bi, rand64());
    end
  endtask

  task automatic run_single();
    logic [SIZE_W-1:0] n;
    logic [31:0]       off;
    n   = SZ_1 << $urandom_range(0, 3);
    off = pick_offset();
    if ($urandom_range(0, 4) != 0) off = off & ~(32'(n) - 32'd1);
    issue_access(1'($urandom_range(0, 1)), ram_base_cfg + off, n,
                 3'($urandom_range(0, 7)), rand64());
  endtask

  task automatic run_noise();
    logic [31:0] addr;
    addr = $urandom_range(0, 1) ? $urandom() : ram_base_cfg + pick_offset();
    issue_access(1'($urandom_range(0, 1)), addr, 7'($urandom_range(0, 127)),
                 3'($urandom_range(0, 7)), rand64());
  endtask

  // ------------------------------------------------------------------- tests

  task automatic test_directed_access;
    gaps_on = 1'b0;
    issue_access(OP_WRITE, 32'h0, SZ_8, 3'd0, 64'hFFFF_FFFF_FFFF_FFFF);
    issue_access(OP_READ,  32'h0, SZ_8, 3'd0, 64'h0);
    issue_access(OP_WRITE, 32'h7, SZ_1, 3'd0, 64'hFFFF_FFFF_FFFF_FF00);
    issue_access(OP_READ,  32'h6, SZ_2, 3'd0, 64'h0);
    // misaligned: lane is rounded down to the size
    issue_access(OP_READ,  32'h5, SZ_4, 3'd0, 64'h0);
    issue_access(OP_WRITE, 32'h3, SZ_2, 3'd0, 64'h0000_0000_0000_1234);
    // beat is ignored for single-word sizes
    issue_access(OP_WRITE, 32'hC, SZ_4, 3'd5, 64'h0000_0000_DEAD_BEEF);
    issue_access(OP_READ,  32'h8, SZ_8, 3'd0, 64'h0);
    // bad sizes still report the page on writes
    issue_access(OP_WRITE, 32'h1400, 7'd0, 3'd0, 64'h0);
    issue_access(OP_READ,  32'h0, 7'd3, 3'd0, 64'h0);
    issue_access(OP_WRITE, 32'hFFFF_FFFF, 7'd127, 3'd7, 64'hFFFF_FFFF_FFFF_FFFF);
    issue_access(OP_READ,  32'h10, 7'd65, 3'd0, 64'h0);
    // unaligned 16-byte burst straddling a page
    issue_access(OP_WRITE, 32'h3F8, SZ_16, 3'd0, 64'h0123_4567_89AB_CDEF);
    issue_access(OP_WRITE, 32'h3F8, SZ_16, 3'd1, 64'hFEDC_BA98_7654_3210);
    issue_access(OP_READ,  32'h3F8, SZ_16, 3'd0, 64'h0);
    issue_access(OP_READ,  32'h3F8, SZ_16, 3'd5, 64'h0);
    // end offset wraps past 2^32
    issue_access(OP_WRITE, 32'hFFFF_FFC8, SZ_64, 3'd0, 64'hA5A5_A5A5_5A5A_5A5A);
    issue_access(OP_WRITE, 32'hFFFF_FFC8, SZ_64, 3'd7, 64'h0000_0000_0000_0000);
    // offsets past the RAM alias onto low words
    issue_access(OP_READ,  RAM_BYTES, SZ_8, 3'd0, 64'h0);
    issue_access(OP_READ,  RAM_BYTES - 8, SZ_32, 3'd1, 64'h0);
    issue_access(OP_WRITE, RAM_BYTES - 32, SZ_32, 3'd3, 64'h0);
    issue_access(OP_READ,  RAM_BYTES - 1, SZ_1, 3'd0, 64'h0);
    drain();
  endtask

  task automatic test_fb_window;
    gaps_on = 1'b0;
    set_config(32'h1000_0000, 32'h1000_2000, 32'h0000_0100);
    issue_access(OP_WRITE, 32'h1000_1FFF, SZ_1, 3'd0, 64'h11);
    issue_access(OP_WRITE, 32'h1000_2000, SZ_1, 3'd0, 64'h22);
    issue_access(OP_WRITE, 32'h1000_20F8, SZ_8, 3'd0, 64'h33);
    issue_access(OP_WRITE, 32'h1000_2100, SZ_1, 3'd0, 64'h44);
    issue_access(OP_WRITE, 32'h1000_1FC0, SZ_64, 3'd0, 64'h55);
    issue_access(OP_WRITE, 32'h1000_1FC8, SZ_64, 3'd0, 64'h66);
    issue_access(OP_READ,  32'h1000_2000, SZ_8, 3'd0, 64'h0);
    issue_access(OP_WRITE, 32'h0FFF_FFFE, SZ_2, 3'd0, 64'h77);
    drain();
  endtask

  task automatic test_random_traffic;
    logic [31:0] rb;
    int          target;
    int          sel;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      rb = $urandom();
      case (p)
        0: set_config(32'h0, 32'h0000_1000, 32'h0000_0800);
        1: set_config(32'hFFFF_FFFF, 32'h0000_0FFF, 32'h0000_0010);
        2: set_config(rb, rb + $urandom_range(0, 8191), 32'h1);
        3: set_config(32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        4: set_config(rb, $urandom(), 32'h0);
        5: set_config(32'h7FFF_FFF0, 32'h7FFF_FFD0, 32'h0000_0040);
        6: set_config(rb & ~32'hFFF, $urandom(), $urandom());
        default: set_config(32'h0, 32'h0, 32'h0000_2000);
      endcase
      gaps_on  = (p % 3) != 2;
      run_left = $urandom_range(1, 12);
      target   = words_sent + PHASE_ITEMS;
      while (words_sent < target) begin
        sel = $urandom_range(0, 99);
        if (sel < 50) run_burst(1'b0);
        else if (sel < 80) run_single();
        else if (sel < 92) run_noise();
        else run_burst(1'b1);
      end
      drain();
    end
  endtask

  initial begin
    for (int i = 0; i < RAM_WORDS_TB; i++) ram_shadow[i] = '0;
    ram_base_cfg    = '0;
    fb_base_cfg     = '0;
    fb_size_cfg     = '0;
    rst_n           = 1'b0;
    start           = 1'b0;
    in_operation    = OP_READ;
    in_address      = '0;
    in_access_bytes = '0;
    in_beat         = '0;
    in_write_data   = '0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    gaps_on         = 1'b0;
    run_left        = 1;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    test_directed_access();
    test_fb_window();
    test_random_traffic();

    repeat (16) @(posedge clk);
    $display("covered %0d words: %0d reads, %0d writes, %0d bad sizes, %0d cfg writes",
             words_sent, reads_ok, writes_ok, bad_sizes, cfg_writes);
    $display("window hits %0d, end-page reports %0d, mismatches %0d",
             fb_hits, end_page_hits, errors);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
